// ===== rtl/nsfp_pkg.sv =====
// Package for the NMEA sentence field parser.
// Holds the record type, character codes and constant tables; no dependencies.
package nsfp_pkg;

  localparam int unsigned MantWidth      = 40;
  localparam int unsigned FieldWidth     = 5;
  localparam int unsigned DefMantDigits  = 12;
  localparam int unsigned DefMaxFields   = 20;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChPoint  = 8'h2E;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChVt     = 8'h0B;
  localparam logic [7:0] ChFf     = 8'h0C;

  // Sentence kinds
  localparam logic [1:0] KindGga = 2'd0;
  localparam logic [1:0] KindRmc = 2'd1;
  localparam logic [1:0] KindVtg = 2'd2;

  // Tag candidate masks
  localparam logic [2:0] TagGga = 3'b001;
  localparam logic [2:0] TagRmc = 3'b010;
  localparam logic [2:0] TagVtg = 3'b100;

  // Tag text after the dollar sign, one row per candidate
  localparam logic [7:0] TagChars [3][5] = '{
    '{8'h47, 8'h50, 8'h47, 8'h47, 8'h41},
    '{8'h47, 8'h50, 8'h52, 8'h4D, 8'h43},
    '{8'h47, 8'h50, 8'h56, 8'h54, 8'h47}
  };

  // Bounds for "integer part equals two": 2*10^f <= m < 3*10^f
  localparam logic [51:0] TwoPow [16] = '{
    52'd2, 52'd20, 52'd200, 52'd2000, 52'd20000, 52'd200000, 52'd2000000,
    52'd20000000, 52'd200000000, 52'd2000000000, 52'd20000000000,
    52'd200000000000, 52'd2000000000000, 52'd20000000000000,
    52'd200000000000000, 52'd2000000000000000
  };
  localparam logic [51:0] ThreePow [16] = '{
    52'd3, 52'd30, 52'd300, 52'd3000, 52'd30000, 52'd300000, 52'd3000000,
    52'd30000000, 52'd300000000, 52'd3000000000, 52'd30000000000,
    52'd300000000000, 52'd3000000000000, 52'd30000000000000,
    52'd300000000000000, 52'd3000000000000000
  };

  typedef struct packed {
    logic [1:0]            sentence_kind;
    logic [FieldWidth-1:0] field_number;
    logic [MantWidth-1:0]  mantissa;
    logic [3:0]            frac_digits;
    logic                  negative;
    logic [7:0]            first_char;
    logic [6:0]            pair_one;
    logic [6:0]            pair_two;
    logic [6:0]            pair_three;
    logic                  overflow;
    logic                  last;
  } rec_t;

  // Saturation limit: min(10^digits - 1, 2^40 - 1), evaluated at elaboration
  function automatic logic [MantWidth-1:0] mant_limit(int unsigned digits);
    logic [63:0] v;
    v = 64'd1;
    for (int unsigned i = 0; i < digits && i < 18; i++) begin
      v = v * 64'd10;
    end
    v = v - 64'd1;
    if (v > {24'd0, {MantWidth{1'b1}}}) begin
      v = {24'd0, {MantWidth{1'b1}}};
    end
    return v[MantWidth-1:0];
  endfunction

  function automatic logic is_dig(logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChVt) || (c == ChFf);
  endfunction

endpackage

// ===== rtl/nsfp_if.sv =====
// Handshake channels of the NMEA sentence field parser.
// Depends on nsfp_pkg for field widths.
interface nsfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  modport source (output valid, byte_in, input ready);
  modport sink   (input valid, byte_in, output ready);
  modport mon    (input valid, byte_in, ready);
endinterface

interface nsfp_rec_if;
  import nsfp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [1:0]            sentence_kind;
  logic [FieldWidth-1:0] field_number;
  logic [MantWidth-1:0]  mantissa;
  logic [3:0]            frac_digits;
  logic                  negative;
  logic [7:0]            first_char;
  logic [6:0]            pair_one;
  logic [6:0]            pair_two;
  logic [6:0]            pair_three;
  logic                  overflow;
  logic                  last;
  modport source (output valid, sentence_kind, field_number, mantissa, frac_digits,
                  negative, first_char, pair_one, pair_two, pair_three, overflow,
                  last, input ready);
  modport sink   (input valid, sentence_kind, field_number, mantissa, frac_digits,
                  negative, first_char, pair_one, pair_two, pair_three, overflow,
                  last, output ready);
  modport mon    (input valid, ready, sentence_kind, field_number, mantissa,
                  frac_digits, negative, first_char, pair_one, pair_two, pair_three,
                  overflow, last);
endinterface

// ===== rtl/nsfp_core.sv =====
// Sentence state and per-character update of the NMEA field parser.
// Depends on nsfp_pkg; one character is consumed per step_i pulse.
module nsfp_core import nsfp_pkg::*; #(
  parameter int unsigned MANTISSA_DIGITS = DefMantDigits,
  parameter int unsigned MAX_FIELDS      = DefMaxFields
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] char_i,
  output logic       res_valid_o,
  output rec_t       res_o
);

  localparam logic [MantWidth-1:0]  MantLim = mant_limit(MANTISSA_DIGITS);
  localparam logic [FieldWidth-1:0] FieldMax = FieldWidth'(MAX_FIELDS);

  logic                  in_sent_q, in_sent_d;
  logic [2:0]            tag_q, tag_d;
  logic [1:0]            kind_q, kind_d;
  logic [FieldWidth-1:0] field_q, field_d;
  logic [3:0]            pos_q, pos_d;
  logic [MantWidth-1:0]  acc_q, acc_d;
  logic [3:0]            frac_q, frac_d;
  logic                  point_q, point_d;
  logic                  stop_q, stop_d;
  logic                  sign_q, sign_d;
  logic [7:0]            first_q, first_d;
  logic [6:0]            pair_q [3];
  logic [6:0]            pair_d [3];
  logic                  diff_q, diff_d;
  logic                  sat_q, sat_d;
  logic                  start_q, start_d;
  logic [7:0]            pend_q, pend_d;

  logic [3:0]            dig;
  logic [MantWidth+3:0]  nv;
  logic                  used;
  logic [1:0]            pidx;
  logic [6:0]            pval;

  assign dig = 4'(char_i - ChZero);
  assign nv  = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + {{MantWidth{1'b0}}, dig};
  assign pidx = pos_q[2:1];

  // Decide whether the current field is reported for this sentence type
  always_comb begin
    unique case (kind_q)
      KindGga: used = (field_q >= 5'd1 && field_q <= 5'd9) || field_q == 5'd11 ||
                      ((field_q == 5'd13 || field_q == 5'd14) && diff_q);
      KindRmc: used = field_q >= 5'd1 && field_q <= 5'd12;
      default: used = field_q == 5'd1 || field_q == 5'd3 || field_q == 5'd5 ||
                      field_q == 5'd7 || field_q == 5'd9;
    endcase
  end

  // Value of a completed character pair
  always_comb begin
    pval = 7'd0;
    if (is_dig(pend_q)) begin
      pval = is_dig(char_i) ? 7'(pend_q - ChZero) * 7'd10 + 7'(dig) : 7'(pend_q - ChZero);
    end else if (is_blank(pend_q) || pend_q == ChPlus) begin
      pval = is_dig(char_i) ? 7'(dig) : 7'd0;
    end
  end

  // Next state and result for one character
  always_comb begin
    logic clr;
    clr       = 1'b0;
    in_sent_d = in_sent_q;
    tag_d     = tag_q;
    kind_d    = kind_q;
    field_d   = field_q;
    pos_d     = pos_q;
    acc_d     = acc_q;
    frac_d    = frac_q;
    point_d   = point_q;
    stop_d    = stop_q;
    sign_d    = sign_q;
    first_d   = first_q;
    pair_d    = pair_q;
    diff_d    = diff_q;
    sat_d     = sat_q;
    start_d   = start_q;
    pend_d    = pend_q;
    res_valid_o = 1'b0;
    res_o.sentence_kind = kind_q;
    res_o.field_number  = field_q;
    res_o.mantissa      = acc_q;
    res_o.frac_digits   = frac_q;
    res_o.negative      = sign_q;
    res_o.first_char    = first_q;
    res_o.pair_one      = pair_q[0];
    res_o.pair_two      = pair_q[1];
    res_o.pair_three    = pair_q[2];
    res_o.overflow      = sat_q;
    res_o.last          = 1'b0;

    if (char_i == ChDollar) begin
      // Open a fresh sentence, dropping any open one
      in_sent_d = 1'b1;
      tag_d     = 3'b111;
      kind_d    = KindGga;
      field_d   = '0;
      diff_d    = 1'b0;
      clr       = 1'b1;
    end else if (in_sent_q) begin
      if (char_i == ChStar || char_i == ChCr || char_i == ChLf) begin
        // Close the sentence with a last record, bare if field unused
        in_sent_d = 1'b0;
        res_valid_o = field_q != '0;
        res_o.last  = 1'b1;
        if (!used) begin
          res_o.field_number = '0;
          res_o.mantissa     = '0;
          res_o.frac_digits  = '0;
          res_o.negative     = 1'b0;
          res_o.first_char   = '0;
          res_o.pair_one     = '0;
          res_o.pair_two     = '0;
          res_o.pair_three   = '0;
          res_o.overflow     = 1'b0;
        end
      end else if (char_i == ChComma) begin
        if (field_q == '0) begin
          // End of tag: accept only a complete single match
          if (pos_q == 4'd5 && (tag_q == TagGga || tag_q == TagRmc || tag_q == TagVtg)) begin
            kind_d  = (tag_q == TagGga) ? KindGga : ((tag_q == TagRmc) ? KindRmc : KindVtg);
            field_d = 5'd1;
            clr     = 1'b1;
          end else begin
            in_sent_d = 1'b0;
          end
        end else begin
          // Status field of GGA enables the differential fields
          if (kind_q == KindGga && field_q == 5'd6) begin
            diff_d = !sign_q && !sat_q && ({12'd0, acc_q} >= TwoPow[frac_q]) &&
                     ({12'd0, acc_q} < ThreePow[frac_q]);
          end
          res_valid_o = used;
          if (field_q < FieldMax) begin
            field_d = field_q + 5'd1;
          end
          clr = 1'b1;
        end
      end else if (field_q == '0) begin
        // Tag character: drop candidates that disagree
        for (int i = 0; i < 3; i++) begin
          if (pos_q >= 4'd5 || TagChars[i][pos_q[2:0]] != char_i) begin
            tag_d[i] = 1'b0;
          end
        end
        if (pos_q != 4'hF) pos_d = pos_q + 4'd1;
      end else begin
        // Field character
        if (pos_q == 4'd0) first_d = char_i;
        if (pos_q < 4'd6) begin
          if (!pos_q[0]) begin
            pend_d       = char_i;
            pair_d[pidx] = is_dig(char_i) ? 7'(dig) : 7'd0;
          end else begin
            pair_d[pidx] = pval;
          end
        end
        if (!stop_q && !(!start_q && is_blank(char_i))) begin
          start_d = 1'b1;
          if (!start_q && (char_i == ChPlus || char_i == ChMinus)) begin
            sign_d = char_i == ChMinus;
          end else if (is_dig(char_i)) begin
            if (!sat_q && !(point_q && frac_q == 4'hF)) begin
              if (nv > {4'd0, MantLim}) begin
                acc_d = MantLim;
                sat_d = 1'b1;
              end else begin
                acc_d = nv[MantWidth-1:0];
                if (point_q) frac_d = frac_q + 4'd1;
              end
            end
          end else if (char_i == ChPoint && !point_q) begin
            point_d = 1'b1;
          end else begin
            stop_d = 1'b1;
          end
        end
        if (pos_q != 4'hF) pos_d = pos_q + 4'd1;
      end
    end

    // Clear the per-field state
    if (clr) begin
      pos_d   = '0;
      acc_d   = '0;
      frac_d  = '0;
      point_d = 1'b0;
      stop_d  = 1'b0;
      sign_d  = 1'b0;
      first_d = '0;
      pair_d  = '{7'd0, 7'd0, 7'd0};
      sat_d   = 1'b0;
      start_d = 1'b0;
      pend_d  = '0;
    end
  end

  // Advance the state on each consumed character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sent_q <= 1'b0;
      tag_q     <= 3'b111;
      kind_q    <= KindGga;
      field_q   <= '0;
      pos_q     <= '0;
      acc_q     <= '0;
      frac_q    <= '0;
      point_q   <= 1'b0;
      stop_q    <= 1'b0;
      sign_q    <= 1'b0;
      first_q   <= '0;
      pair_q    <= '{7'd0, 7'd0, 7'd0};
      diff_q    <= 1'b0;
      sat_q     <= 1'b0;
      start_q   <= 1'b0;
      pend_q    <= '0;
    end else if (step_i) begin
      in_sent_q <= in_sent_d;
      tag_q     <= tag_d;
      kind_q    <= kind_d;
      field_q   <= field_d;
      pos_q     <= pos_d;
      acc_q     <= acc_d;
      frac_q    <= frac_d;
      point_q   <= point_d;
      stop_q    <= stop_d;
      sign_q    <= sign_d;
      first_q   <= first_d;
      pair_q    <= pair_d;
      diff_q    <= diff_d;
      sat_q     <= sat_d;
      start_q   <= start_d;
      pend_q    <= pend_d;
    end
  end

endmodule

// ===== rtl/nmea_sentence_field_parser.sv =====
// NMEA sentence field parser, top level: input register, parser core, result register.
// Depends on nsfp_pkg, nsfp_if and nsfp_core.
//
// Feed the receiver text one character per word on byte_i; each comma or end-of-sentence
// character may produce one field record on rec_o. A character taken from byte_i sits in
// the input register until the parser core consumes it; that step also loads its record
// (if any) into the result register, from which the record is offered on rec_o. The rate
// is one character per cycle while rec_o is drained. A record left waiting on rec_o holds
// the core, and byte_i is not ready while the input register holds a word that cannot be
// consumed.
module nmea_sentence_field_parser import nsfp_pkg::*; #(
  parameter int unsigned MANTISSA_DIGITS = DefMantDigits,
  parameter int unsigned MAX_FIELDS      = DefMaxFields
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  nsfp_byte_if.sink     byte_i,
  nsfp_rec_if.source    rec_o
);

  logic       in_vld_q;
  logic [7:0] char_q;
  logic       step;
  logic       res_vld;
  rec_t       res;
  logic       out_vld_q;
  rec_t       out_q;

  // Consume when the result register is free or drains this cycle
  assign step         = in_vld_q && (!out_vld_q || rec_o.ready);
  assign byte_i.ready = !in_vld_q || step;

  // Hold the incoming word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (byte_i.valid && byte_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      char_q <= byte_i.byte_in;
    end
  end

  nsfp_core #(
    .MANTISSA_DIGITS(MANTISSA_DIGITS),
    .MAX_FIELDS     (MAX_FIELDS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .char_i     (char_q),
    .res_valid_o(res_vld),
    .res_o      (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= res_vld;
    end else if (rec_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_vld) begin
      out_q <= res;
    end
  end

  assign rec_o.valid         = out_vld_q;
  assign rec_o.sentence_kind = out_q.sentence_kind;
  assign rec_o.field_number  = out_q.field_number;
  assign rec_o.mantissa      = out_q.mantissa;
  assign rec_o.frac_digits   = out_q.frac_digits;
  assign rec_o.negative      = out_q.negative;
  assign rec_o.first_char    = out_q.first_char;
  assign rec_o.pair_one      = out_q.pair_one;
  assign rec_o.pair_two      = out_q.pair_two;
  assign rec_o.pair_three    = out_q.pair_three;
  assign rec_o.overflow      = out_q.overflow;
  assign rec_o.last          = out_q.last;

endmodule

// ===== rtl/nsfp_checker.sv =====
// Port-level checks for the NMEA sentence field parser, bound to the top level.
// Depends on nsfp_pkg for field widths.
module nsfp_checker import nsfp_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  valid_i,
  input logic                  ready_i,
  input logic [1:0]            kind_i,
  input logic [FieldWidth-1:0] field_i,
  input logic [MantWidth-1:0]  mantissa_i,
  input logic                  overflow_i,
  input logic                  last_i
);

  // A stalled word stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i)
    else $error("record dropped while stalled");

  // Kind is one of the three sentence types
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> kind_i != 2'd3)
    else $error("bad sentence kind");

  // Only closing records may carry field number zero
  a_bare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && field_i == '0 |-> last_i)
    else $error("bare record not marked last");

  // Overflow implies a saturated, nonzero mantissa
  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && overflow_i |-> mantissa_i != '0 && field_i != '0)
    else $error("overflow with empty mantissa");

endmodule

bind nmea_sentence_field_parser nsfp_checker u_nsfp_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .valid_i   (rec_o.valid),
  .ready_i   (rec_o.ready),
  .kind_i    (rec_o.sentence_kind),
  .field_i   (rec_o.field_number),
  .mantissa_i(rec_o.mantissa),
  .overflow_i(rec_o.overflow),
  .last_i    (rec_o.last)
);
